FILE: rtl/twc_pkg.sv
// twc_pkg: shared types, codes and constants of the triggered window capture block
// no dependencies; compiled before every other file of the block
`default_nettype none

package twc_pkg;

   // fixed field widths
   localparam int unsigned RATE_WIDTH   = 23;
   localparam int unsigned MS_WIDTH     = 6;
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned VALUE_WIDTH  = 16;
   localparam int unsigned COUNT_WIDTH  = 32;
   localparam int unsigned WINDOW_WIDTH = 14;
   localparam int unsigned INDEX_WIDTH  = 16;

   // configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = RATE_WIDTH;

   // register reset values and window_ms clamp bounds
   localparam logic [RATE_WIDTH-1:0] RATE_RESET = 23'd2048000;
   localparam logic [MS_WIDTH-1:0]   MS_RESET   = 6'd20;
   localparam logic [MS_WIDTH-1:0]   MS_LOW     = 6'd5;
   localparam logic [MS_WIDTH-1:0]   MS_HIGH    = 6'd50;

   // default buffer size in bytes
   localparam int unsigned MAX_WINDOW_BYTES_DEFAULT = 12000;

   // window size arithmetic: ceil(rate * ms / 8000)
   // 8000 = 64 * 125; the divide by 125 is a multiply by ceil(2^30 / 125),
   // exact for every quotient input below 2^23
   localparam int unsigned PROD_WIDTH   = RATE_WIDTH + MS_WIDTH;
   localparam int unsigned ROUND_UP     = 7999;
   localparam int unsigned PRE_SHIFT    = 6;
   localparam int unsigned MID_WIDTH    = PROD_WIDTH - PRE_SHIFT;
   localparam int unsigned RECIP_WIDTH  = 24;
   localparam int unsigned RECIP_SHIFT  = 30;
   localparam logic [RECIP_WIDTH-1:0] RECIP_125 = 24'd8589935;
   localparam int unsigned FULL_WIDTH   = MID_WIDTH + RECIP_WIDTH;
   localparam int unsigned QUOT_WIDTH   = 16;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SAMPLE_RATE = 1'b0,
      REG_WINDOW_MS   = 1'b1
   } reg_index_type;

   // input operation codes
   typedef enum logic {
      OP_DATA    = 1'b0,
      OP_TRIGGER = 1'b1
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_DATA    = 2'd2,
      KIND_DROPPED = 2'd3
   } kind_type;

   // one result item
   typedef struct packed {
      kind_type               kind;
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
      logic [COUNT_WIDTH-1:0] triggers_accepted;
      logic [COUNT_WIDTH-1:0] triggers_rejected;
      logic [COUNT_WIDTH-1:0] windows_done;
   } result_type;

   // status of the window size unit
   typedef struct packed {
      logic                    busy;
      logic [WINDOW_WIDTH-1:0] window_bytes;
   } window_status_type;

endpackage

`default_nettype wire

FILE: rtl/twc_if.sv
// twc channel interfaces: request, response and configuration write channels
// depends on twc_pkg for field widths
`default_nettype none

interface twc_req_if;
   import twc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [BYTE_WIDTH-1:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface twc_rsp_if;
   import twc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [VALUE_WIDTH-1:0] value;
   logic                   last;
   logic [COUNT_WIDTH-1:0] triggers_accepted;
   logic [COUNT_WIDTH-1:0] triggers_rejected;
   logic [COUNT_WIDTH-1:0] windows_done;

   modport source (output valid, output kind, output value, output last,
                   output triggers_accepted, output triggers_rejected,
                   output windows_done, input ready);
   modport sink   (input valid, input kind, input value, input last,
                   input triggers_accepted, input triggers_rejected,
                   input windows_done, output ready);
endinterface

interface twc_csr_if;
   import twc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/triggered_window_capture.sv
// triggered_window_capture: top level of the triggered window capture block
// depends on twc_pkg, the twc interfaces, twc_window, twc_capture, twc_out_buffer
//
//   channel   direction  carries
//   req_if    in         operation, data_byte
//   rsp_if    out        kind, value, last, triggers_accepted/rejected, windows_done
//   csr_if    in         index (0 sample_rate_hz, 1 window_ms), wdata
//
// one item per cycle while req_if.ready is high: the state update and result are
// formed in the transfer cycle, and the result reaches rsp_if from the result register
// a configuration write starts a 4-stage window size pipeline (multiply, round,
// reciprocal multiply, clamp); req_if.ready is low from the write cycle until the
// clamp stage holds the new size, and likewise after reset is released
// a stalled response fills a one-entry skid, after which req_if.ready drops
// reset is synchronous and active high
`default_nettype none

module triggered_window_capture #(
   parameter int unsigned MAX_WINDOW_BYTES = twc_pkg::MAX_WINDOW_BYTES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   twc_req_if.sink   req_if,
   twc_rsp_if.source rsp_if,
   twc_csr_if.sink   csr_if
);
   import twc_pkg::*;

   window_status_type win_status;
   result_type        result;
   logic              skid_full;
   logic              req_fire;

   assign req_if.ready = !win_status.busy && !skid_full;
   assign req_fire     = req_if.valid && req_if.ready;

   // window size from the configuration
   twc_window #(
      .MAX_WINDOW_BYTES (MAX_WINDOW_BYTES)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .status (win_status)
   );

   // capture state machine and counters
   twc_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_fire),
      .operation    (req_if.operation),
      .data_byte    (req_if.data_byte),
      .window_bytes (win_status.window_bytes),
      .result       (result)
   );

   // result register and skid
   twc_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .result    (result),
      .rsp_if    (rsp_if),
      .skid_full (skid_full)
   );

   // no transfer while the window size is being worked out
   assert property (@(posedge clock) disable iff (reset)
      win_status.busy |-> !req_if.ready)
      else $error("request taken while window size unit busy");

   // last only marks a data byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.last) |-> (rsp_if.kind == KIND_DATA))
      else $error("last set on a non-data result");

   // the skid holds an item only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_if.valid)
      else $error("skid occupied with empty result register");

   // a transfer into a stalled output leaves a result on the channel
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && skid_full))
      else $error("result lost on a stalled response");

endmodule

`default_nettype wire

FILE: rtl/twc_window.sv
// twc_window: configuration registers and the pipelined window size unit
// depends on twc_pkg and twc_csr_if
`default_nettype none

module twc_window #(
   parameter int unsigned MAX_WINDOW_BYTES = twc_pkg::MAX_WINDOW_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   twc_csr_if.sink                         csr_if,
   output      twc_pkg::window_status_type status
);
   import twc_pkg::*;

   localparam logic [QUOT_WIDTH-1:0]   MAX_QUOT = QUOT_WIDTH'(MAX_WINDOW_BYTES);
   localparam logic [WINDOW_WIDTH-1:0] MAX_WIN  = WINDOW_WIDTH'(MAX_WINDOW_BYTES);

   logic [RATE_WIDTH-1:0]   rate_ff;
   logic [MS_WIDTH-1:0]     ms_ff;
   logic                    start_ff;
   logic                    v1_ff, v2_ff, v3_ff;
   logic [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic [MID_WIDTH-1:0]    mid_ff, mid_in;
   logic [QUOT_WIDTH-1:0]   quot_ff, quot_in;
   logic [WINDOW_WIDTH-1:0] window_ff, window_in;
   logic [MS_WIDTH-1:0]     ms_clamped;
   logic [FULL_WIDTH-1:0]   full;
   logic                    csr_fire;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;

   // configuration registers; every write restarts the size computation
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         ms_ff    <= MS_RESET;
         start_ff <= 1'b1;
      end else begin
         start_ff <= csr_fire;
         if (csr_fire) begin
            case (reg_index_type'(csr_if.index))
               REG_SAMPLE_RATE: rate_ff <= csr_if.wdata;
               REG_WINDOW_MS:   ms_ff   <= csr_if.wdata[MS_WIDTH-1:0];
               default:         ;
            endcase
         end
      end
   end

   // clamp milliseconds and form rate * ms
   always_comb begin
      if (ms_ff < MS_LOW) begin
         ms_clamped = MS_LOW;
      end else if (ms_ff > MS_HIGH) begin
         ms_clamped = MS_HIGH;
      end else begin
         ms_clamped = ms_ff;
      end
      prod_in = PROD_WIDTH'(rate_ff) * PROD_WIDTH'(ms_clamped);
   end

   // round up and divide by 64
   assign mid_in = MID_WIDTH'((PROD_WIDTH'(prod_ff) + PROD_WIDTH'(ROUND_UP)) >> PRE_SHIFT);

   // divide by 125 through the reciprocal
   assign full    = FULL_WIDTH'(mid_ff) * FULL_WIDTH'(RECIP_125);
   assign quot_in = QUOT_WIDTH'(full >> RECIP_SHIFT);

   // clamp to one through the buffer size
   always_comb begin
      if (quot_ff == '0) begin
         window_in = WINDOW_WIDTH'(1);
      end else if (quot_ff > MAX_QUOT) begin
         window_in = MAX_WIN;
      end else begin
         window_in = quot_ff[WINDOW_WIDTH-1:0];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (start_ff) begin
         prod_ff <= prod_in;
      end
      if (v1_ff) begin
         mid_ff <= mid_in;
      end
      if (v2_ff) begin
         quot_ff <= quot_in;
      end
      if (v3_ff) begin
         window_ff <= window_in;
      end
   end

   assign status.busy         = csr_fire || start_ff || v1_ff || v2_ff || v3_ff;
   assign status.window_bytes = window_ff;

endmodule

`default_nettype wire

FILE: rtl/twc_capture.sv
// twc_capture: capture state, counters and the result of each accepted item
// depends on twc_pkg
`default_nettype none

module twc_capture (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic                                 operation,
   input  wire logic [twc_pkg::BYTE_WIDTH-1:0]       data_byte,
   input  wire logic [twc_pkg::WINDOW_WIDTH-1:0]     window_bytes,
   output      twc_pkg::result_type                  result
);
   import twc_pkg::*;

   logic                    capturing_ff, capturing_in;
   logic [WINDOW_WIDTH-1:0] taken_ff, taken_in;
   logic [INDEX_WIDTH-1:0]  index_ff, index_in;
   logic [COUNT_WIDTH-1:0]  accepted_ff, accepted_in;
   logic [COUNT_WIDTH-1:0]  rejected_ff, rejected_in;
   logic [COUNT_WIDTH-1:0]  done_ff, done_in;
   logic [WINDOW_WIDTH-1:0] taken_next;

   assign taken_next = taken_ff + WINDOW_WIDTH'(1);

   // next state and result for the item at the port
   always_comb begin
      capturing_in = capturing_ff;
      taken_in     = taken_ff;
      index_in     = index_ff;
      accepted_in  = accepted_ff;
      rejected_in  = rejected_ff;
      done_in      = done_ff;
      result.kind  = KIND_NONE;
      result.value = '0;
      result.last  = 1'b0;
      if (op_type'(operation) == OP_TRIGGER) begin
         if (capturing_ff) begin
            rejected_in = rejected_ff + COUNT_WIDTH'(1);
            result.kind = KIND_DROPPED;
         end else begin
            accepted_in  = accepted_ff + COUNT_WIDTH'(1);
            result.value = index_ff;
            index_in     = index_ff + INDEX_WIDTH'(1);
            taken_in     = '0;
            capturing_in = 1'b1;
            result.kind  = KIND_HEADER;
         end
      end else if (capturing_ff) begin
         taken_in     = taken_next;
         result.kind  = KIND_DATA;
         result.value = VALUE_WIDTH'(data_byte);
         // window may have shrunk below the count, so greater-or-equal
         if (taken_next >= window_bytes) begin
            result.last  = 1'b1;
            capturing_in = 1'b0;
            done_in      = done_ff + COUNT_WIDTH'(1);
         end
      end
      result.triggers_accepted = accepted_in;
      result.triggers_rejected = rejected_in;
      result.windows_done      = done_in;
   end

   // state update on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         taken_ff     <= '0;
         index_ff     <= '0;
         accepted_ff  <= '0;
         rejected_ff  <= '0;
         done_ff      <= '0;
      end else if (accept) begin
         capturing_ff <= capturing_in;
         taken_ff     <= taken_in;
         index_ff     <= index_in;
         accepted_ff  <= accepted_in;
         rejected_ff  <= rejected_in;
         done_ff      <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/twc_out_buffer.sv
// twc_out_buffer: result register with a skid stage in front of the response channel
// depends on twc_pkg and twc_rsp_if
`default_nettype none

module twc_out_buffer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire twc_pkg::result_type result,
   twc_rsp_if.source                rsp_if,
   output      logic                skid_full
);
   import twc_pkg::*;

   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_if.ready;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || load;
         skid_valid_ff <= 1'b0;
      end else if (load) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload: skid drains first, a new item parks in the skid when stalled
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (load) begin
            out_ff <= result;
         end
      end else if (load) begin
         skid_ff <= result;
      end
   end

   assign skid_full                = skid_valid_ff;
   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.kind              = out_ff.kind;
   assign rsp_if.value             = out_ff.value;
   assign rsp_if.last              = out_ff.last;
   assign rsp_if.triggers_accepted = out_ff.triggers_accepted;
   assign rsp_if.triggers_rejected = out_ff.triggers_rejected;
   assign rsp_if.windows_done      = out_ff.windows_done;

endmodule

`default_nettype wire
